// ===== rtl/core/sinepa_pkg.sv =====
package sinepa_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int COUNT_BITS      = 24;

	localparam int TAB_N       = 1 << TABLE_ADDR_BITS;
	localparam int MAG_W       = 15;
	localparam int AMP_W       = 15;
	localparam int PROD_W      = MAG_W + AMP_W;
	localparam int PROD_SHIFT  = 31 - SAMPLE_BITS;
	localparam int FULL_SCALE  = 32767;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int STEP_W      = 32;
	localparam int SCOUNT_W    = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;

	localparam logic [STEP_W-1:0]   PHASE_STEP_RST   = 32'd42852281;
	localparam logic [AMP_W-1:0]    AMPLITUDE_RST    = 15'd32767;
	localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = 24'd66150;

	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// One classified sample on its way from the front to the back.
	typedef struct packed {
		logic                       last;
		logic                       neg;
		logic                       full;
		logic [TABLE_ADDR_BITS-1:0] addr;
	} qent_t;

	typedef logic [MAG_W-1:0] sine_tab_t [TAB_N];

	// round(32767 * sin(pi/2 * i / N)) in Q30, Taylor series to x^19.
	function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned idx);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] v;
		x    = (HALF_PI_Q30 * idx + 64'(TAB_N / 2)) >> TABLE_ADDR_BITS;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 64'd0;
		term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
		term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
		term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
		term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
		term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
		term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
		term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
		term = ((term * x2) >> 30) / 64'd272; pos = pos + term;
		term = ((term * x2) >> 30) / 64'd342; neg = neg + term;
		s = (pos > neg) ? (pos - neg) : 64'd0;
		v = (64'(FULL_SCALE) * s + (64'd1 << 29)) >> 30;
		return (v > 64'(FULL_SCALE)) ? MAG_W'(FULL_SCALE) : v[MAG_W-1:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k < TAB_N; k++) begin
			t[k] = quarter_sine(64'(k));
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/sinepa_fifo.sv =====
module sinepa_fifo import sinepa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wr_entry,
	input  logic  pop,
	output qent_t rd_entry,
	output logic  full,
	output logic  nonempty
);

	qent_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !nonempty))
		else $error("queue read while empty");

endmodule

// ===== rtl/core/sinepa_front.sv =====
module sinepa_front import sinepa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                restart,
	input  logic                full,
	input  logic [STEP_W-1:0]   phase_step,
	input  logic [SCOUNT_W-1:0] sample_count,
	output logic                push,
	output qent_t               entry
);

	logic [PHASE_BITS-1:0]      phase_q;
	logic [COUNT_BITS-1:0]      index_q;
	logic [PHASE_BITS-1:0]      ph;
	logic [COUNT_BITS-1:0]      idx;
	logic [COUNT_BITS-1:0]      end_idx;
	logic                       is_last;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] tidx;

	assign push    = in_valid && !full;
	assign ph      = restart ? '0 : phase_q;
	assign idx     = restart ? '0 : index_q;
	assign end_idx = COUNT_BITS'(sample_count) - COUNT_BITS'(1);
	assign is_last = (idx == end_idx);
	assign quad    = ph[PHASE_BITS-1 -: 2];
	assign tidx    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];

	// Odd quadrants read the table mirrored; the mirror of index zero is full scale.
	always_comb begin
		entry.last = is_last;
		entry.neg  = quad[1];
		entry.full = quad[0] && (tidx == '0);
		entry.addr = quad[0] ? (TABLE_ADDR_BITS'(0) - tidx) : tidx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
		end else if (push) begin
			if (is_last) begin
				phase_q <= '0;
				index_q <= '0;
			end else begin
				phase_q <= ph + PHASE_BITS'(phase_step);
				index_q <= idx + COUNT_BITS'(1);
			end
		end
	end

	a_run_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && is_last |=> (phase_q == '0) && (index_q == '0))
		else $error("phase or counter not cleared after last sample");

endmodule

// ===== rtl/core/sinepa_back.sv =====
module sinepa_back import sinepa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nonempty,
	input  qent_t                         q_entry,
	input  logic [AMP_W-1:0]              amplitude,
	input  logic                          out_stall,
	output logic                          pop,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          last
);

	logic                   en;
	logic                   valid_s1;
	logic                   valid_s2;
	logic [MAG_W-1:0]       rom_s1;
	logic                   full_s1;
	logic                   neg_s1;
	logic                   last_s1;
	logic [PROD_W-1:0]      prod_s2;
	logic                   neg_s2;
	logic                   last_s2;
	logic [MAG_W-1:0]       mag;
	logic [SAMPLE_BITS-1:0] mag_sh;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   last_q;

	// Advance the whole pipe unless the output register holds a stalled sample.
	assign en     = !(out_valid_q && out_stall);
	assign pop    = en && q_nonempty;
	assign mag    = full_s1 ? MAG_W'(FULL_SCALE) : rom_s1;
	assign mag_sh = SAMPLE_BITS'(prod_s2 >> PROD_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1   <= SINE_TAB[q_entry.addr];
			full_s1  <= q_entry.full;
			neg_s1   <= q_entry.neg;
			last_s1  <= q_entry.last;
			prod_s2  <= PROD_W'(amplitude) * PROD_W'(mag);
			neg_s2   <= neg_s1;
			last_s2  <= last_s1;
			sample_q <= neg_s2 ? (SAMPLE_BITS'(0) - mag_sh) : mag_sh;
			last_q   <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = $signed(sample_q);
	assign last      = last_q;

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en |=> out_valid_q)
		else $error("sample dropped between product and output stage");

endmodule

// ===== rtl/core/sine_phase_accumulator_oscillator_core.sv =====
// Direct digital synthesis sine oscillator. Each transaction on the input channel
// is one sample tick and yields exactly one transaction on the output channel: a
// signed sample equal to amplitude times the sine of the current phase, with last
// set on the final sample of a run of sample_count samples, after which phase and
// sample counter return to zero; restart clears both before its sample is made.
// While the output is not stalled the block sustains one sample per clock: the
// phase accumulator is a registered loop in the front end, and the back end
// (registered quarter-wave ROM read, amplitude multiply, sign and output
// register) is fully pipelined. A four-entry queue sits between front and back,
// so ticks keep being taken while the output is stalled until the queue fills.
// Configuration writes are always ready and must only be issued while no samples
// are in flight.
module sine_phase_accumulator_oscillator_core import sinepa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	logic [STEP_W-1:0]   phase_step_q;
	logic [AMP_W-1:0]    amplitude_q;
	logic [SCOUNT_W-1:0] sample_count_q;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_nonempty;
	qent_t wr_entry;
	qent_t rd_entry;

	// Register file: writes are registered, unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= PHASE_STEP_RST;
			amplitude_q    <= AMPLITUDE_RST;
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PHASE_STEP:   phase_step_q   <= cfg_data[STEP_W-1:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_W-1:0];
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[SCOUNT_W-1:0];
				default:          phase_step_q   <= phase_step_q;
			endcase
		end
	end

	// Hold off new ticks only while the queue is full.
	assign in_stall = q_full;

	sinepa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.restart      (restart),
		.full         (q_full),
		.phase_step   (phase_step_q),
		.sample_count (sample_count_q),
		.push         (push),
		.entry        (wr_entry)
	);

	sinepa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	sinepa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_entry    (rd_entry),
		.amplitude  (amplitude_q),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.sample     (sample),
		.last       (last)
	);

	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> push)
		else $error("accepted tick not queued");

endmodule
